>>> src/dgws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgws_pkg
// Types and constants shared by the dependency graph worker scheduler.
// ----------------------------------------------------------------------------
package dgws_pkg;

  localparam int unsigned MaxSteps = 32;
  localparam int unsigned IdxW     = $clog2(MaxSteps);
  localparam int unsigned TickW    = 14;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgActiveSteps = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWorkerCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeOffset  = 2'd2;

  localparam logic [5:0] ActiveStepsReset = 6'd26;
  localparam logic [5:0] WorkerCountReset = 6'd5;
  localparam logic [7:0] TimeOffsetReset  = 8'd60;

  localparam logic [1:0] ReqAddEdge = 2'd0;
  localparam logic [1:0] ReqRun     = 2'd1;
  localparam logic [1:0] ReqClear   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SCAN, S_EMIT, S_TICK, S_LAST
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic add_edge;
    logic clear;
    logic init;
    logic act;
    logic tick;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic acted;
    logic finished;
    logic all_done;
    logic any_active;
  } dp_stat_t;

endpackage

>>> src/dgws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgws_req_if / dgws_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface dgws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [4:0] before_step;
  logic [4:0] after_step;
  modport source (output valid, req_type, before_step, after_step, input ready);
  modport sink   (input valid, req_type, before_step, after_step, output ready);
endinterface

interface dgws_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  step_id;
  logic [13:0] done_tick;
  logic        is_last;
  logic        deadlock;
  modport source (output valid, step_id, done_tick, is_last, deadlock, input ready);
  modport sink   (input valid, step_id, done_tick, is_last, deadlock, output ready);
endinterface

>>> src/dgws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgws_datapath
// Dependency matrix, step states and the scan logic that takes one action per cycle while act is set.
// ----------------------------------------------------------------------------
module dgws_datapath import dgws_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [4:0]       before_i,
  input  logic [4:0]       after_i,
  input  logic [5:0]       active_steps_i,
  input  logic [5:0]       worker_count_i,
  input  logic [7:0]       time_offset_i,
  output dp_stat_t         stat_o,
  output logic [IdxW-1:0]  act_idx_o,
  output logic [TickW-1:0] now_o
);

  logic [MaxSteps-1:0] dep_q [MaxSteps];
  logic [MaxSteps-1:0] done_q, active_q;
  logic [TickW-1:0]    fin_q [MaxSteps];
  logic [TickW-1:0]    now_q;
  logic [5:0]          free_q;

  logic [MaxSteps-1:0] span, fin_now, ready, cand;
  logic [IdxW-1:0]     idx;
  logic                found;

  always_comb begin
    for (int i = 0; i < MaxSteps; i++) begin
      span[i]    = (7'(i) < {1'b0, active_steps_i});
      fin_now[i] = active_q[i] && (fin_q[i] == now_q);
      ready[i]   = span[i] && !active_q[i] && !done_q[i] &&
                   ((dep_q[i] & span & ~done_q) == '0);
      cand[i]    = fin_now[i] || (ready[i] && (free_q != '0));
    end
    idx   = '0;
    found = 1'b0;
    for (int i = MaxSteps - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx   = IdxW'(i);
        found = 1'b1;
      end
    end
  end

  assign stat_o.empty      = (active_steps_i == '0);
  assign stat_o.acted      = found;
  assign stat_o.finished   = found && fin_now[idx];
  assign stat_o.all_done   = ((done_q | fin_now & (found ? (MaxSteps'(1) << idx) : '0))
                              & span) == span;
  assign stat_o.any_active = (active_q != '0);
  assign act_idx_o = idx;
  assign now_o     = now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= '0;
      active_q <= '0;
      now_q    <= '0;
      free_q   <= WorkerCountReset;
      for (int i = 0; i < MaxSteps; i++) dep_q[i] <= '0;
    end else begin
      if (cmd_i.clear) begin
        for (int i = 0; i < MaxSteps; i++) dep_q[i] <= '0;
      end else if (cmd_i.add_edge) begin
        dep_q[after_i][before_i] <= 1'b1;
      end
      if (cmd_i.init || cmd_i.clear) begin
        done_q   <= '0;
        active_q <= '0;
        now_q    <= '0;
        free_q   <= worker_count_i;
      end else if (cmd_i.act && found) begin
        if (fin_now[idx]) begin
          active_q[idx] <= 1'b0;
          done_q[idx]   <= 1'b1;
          free_q        <= free_q + 6'd1;
        end else begin
          active_q[idx] <= 1'b1;
          free_q        <= free_q - 6'd1;
        end
      end else if (cmd_i.tick) begin
        now_q <= now_q + TickW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act && found && !fin_now[idx])
      fin_q[idx] <= now_q + TickW'(idx) + TickW'(1) + TickW'(time_offset_i);
  end

endmodule

>>> src/dgws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgws_ctrl
// Sequencer for requests, schedule scan, ticks and result hand-off.
// ----------------------------------------------------------------------------
module dgws_ctrl import dgws_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  dgws_req_if.sink         req,
  dgws_res_if.source       res,
  input  dp_stat_t         stat_i,
  input  logic [IdxW-1:0]  act_idx_i,
  input  logic [TickW-1:0] now_i,
  output dp_cmd_t          cmd_o
);

  state_e state_q, state_d;
  logic [4:0]  id_q, id_d;
  logic [13:0] t_q, t_d;
  logic        last_q, last_d, dl_q, dl_d;
  logic        acc;

  assign req.ready = (state_q == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign res.valid = (state_q == S_EMIT);
  assign res.step_id = id_q;
  assign res.done_tick = t_q;
  assign res.is_last = last_q;
  assign res.deadlock = dl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    t_q  <= t_d;
    dl_q <= dl_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    id_d = id_q; t_d = t_q; last_d = last_q; dl_d = dl_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (req.req_type)
            ReqAddEdge: cmd_o.add_edge = 1'b1;
            ReqClear:   cmd_o.clear = 1'b1;
            ReqRun: begin
              cmd_o.init = 1'b1;
              state_d = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        if (stat_i.empty) begin
          id_d = '0; t_d = '0; last_d = 1'b1; dl_d = 1'b0;
          state_d = S_EMIT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.act = 1'b1;
        if (stat_i.acted) begin
          if (stat_i.finished) begin
            id_d = act_idx_i; t_d = now_i; dl_d = 1'b0;
            last_d = stat_i.all_done;
            state_d = S_EMIT;
          end
        end else if (!stat_i.any_active) begin
          id_d = '0; t_d = now_i; last_d = 1'b1; dl_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_TICK;
        end
      end
      S_TICK: begin
        cmd_o.tick = 1'b1;
        state_d = S_SCAN;
      end
      S_EMIT: begin
        if (res.ready) state_d = last_q ? S_IDLE : S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.step_id)))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req.ready)
    else $error("request accepted while busy");
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.ready && res.is_last) |=> (state_q == S_IDLE))
    else $error("run did not end after last result");

endmodule

>>> src/dependency_graph_worker_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_graph_worker_scheduler_unit
// List scheduler over a dependency bit matrix with a limited worker pool.
// ----------------------------------------------------------------------------
// Edge and clear requests are taken while idle; the next request is accepted the
// cycle after. A run passes an init state, then a scan state that takes one start
// or finish action at a time; a scan with no action while steps are still active
// goes through a tick state, and each result waits in an emit state until
// res.ready. Time is set by the single-action scan loop. Reset is asynchronous;
// it clears the matrix and step states and loads the register defaults.
module dependency_graph_worker_scheduler_unit import dgws_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  dgws_req_if.sink            req,
  dgws_res_if.source          res
);

  logic [5:0] active_q, workers_q;
  logic [7:0] offset_q;
  logic [5:0] active_cap;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [IdxW-1:0]  act_idx;
  logic [TickW-1:0] now_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= ActiveStepsReset;
      workers_q <= WorkerCountReset;
      offset_q  <= TimeOffsetReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgActiveSteps: active_q  <= cfg_data_i[5:0];
        CfgWorkerCount: workers_q <= cfg_data_i[5:0];
        CfgTimeOffset:  offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign active_cap = (active_q > 6'(MaxSteps)) ? 6'(MaxSteps) : active_q;

  dgws_ctrl u_ctrl (
    .clk_i, .rst_ni, .req, .res,
    .stat_i(stat), .act_idx_i(act_idx), .now_i(now_t), .cmd_o(cmd)
  );

  dgws_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .before_i(req.before_step), .after_i(req.after_step),
    .active_steps_i(active_cap), .worker_count_i(workers_q),
    .time_offset_i(offset_q),
    .stat_o(stat), .act_idx_o(act_idx), .now_o(now_t)
  );

endmodule
